### rtl/pfc_pkg.sv
// pfc_pkg: shared types and constants of the digraph cipher
`timescale 1ns / 1ps

package pfc_pkg;

   // square geometry and letter codes
   localparam int unsigned SQ_SIDE  = 5;
   localparam int unsigned SQ_CELLS = SQ_SIDE * SQ_SIDE;
   localparam int unsigned ALPHABET = 26;

   localparam logic [4:0] LETTER_I   = 5'd8;
   localparam logic [4:0] LETTER_J   = 5'd9;
   localparam logic [4:0] LETTER_MAX = 5'd25;
   localparam logic [4:0] SQ_FULL    = 5'(SQ_CELLS);

   // request modes
   typedef enum logic [1:0] {
      MODE_KEY    = 2'd0,
      MODE_FINISH = 2'd1,
      MODE_PLAIN  = 2'd2,
      MODE_END    = 2'd3
   } mode_type;

   // letter code and cell index of the square
   typedef logic [4:0] letter_type;
   typedef logic [4:0] cell_idx_type;

   // j shares the cell of i
   function automatic letter_type fold_j(input letter_type l);
      return (l == LETTER_J) ? LETTER_I : l;
   endfunction

endpackage

### rtl/playfair_digraph_cipher.sv
// playfair_digraph_cipher: key square build and digraph encryption
// key letter: written straight into the square memories when the request is accepted
// finish key: one letter of the alphabet per cycle through the fill walk
// pair: POS_A, POS_B, GEOM, CELL_A and CELL_B read the two memories serially, then EMIT_A
//   and EMIT_B register the two letters, each once the output is free; requests stall meanwhile
// reset (synchronous, active high) clears placed set, fill count, open pair and
//   filler (to z); square and position memories hold their contents until written
`timescale 1ns / 1ps

module playfair_digraph_cipher (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_mode,
   input  pfc_pkg::letter_type req_letter,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output pfc_pkg::letter_type rsp_cipher_letter,
   output logic                rsp_last_of_run,
   // filler register write
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [4:0]          csr_filler_letter
);
   import pfc_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_FILL, S_POS_A, S_POS_B, S_GEOM, S_CELL_A, S_CELL_B, S_EMIT_A, S_EMIT_B
   } state_type;

   state_type    state_ff;
   logic [ALPHABET-1:0] placed_ff;
   cell_idx_type fill_ff;
   letter_type   walk_ff;
   letter_type   pend_letter_ff;
   logic         pend_valid_ff;
   logic [4:0]   filler_ff;
   letter_type   a_ff, b_ff, c1_ff;
   cell_idx_type p1_ff;
   logic         rsp_valid_ff;
   letter_type   rsp_letter_ff;
   logic         rsp_last_ff;

   // memories
   letter_type   square_mem [SQ_CELLS];
   cell_idx_type pos_mem    [ALPHABET];
   letter_type   sq_rd_ff;
   cell_idx_type pos_rd_ff;

   logic         accept;
   logic         full;
   logic         out_free;
   logic         emit_now;
   letter_type   filler_now;
   letter_type   req_folded;
   logic         cand_ok;
   letter_type   cand;
   logic         place_en;
   letter_type   pos_addr;
   cell_idx_type sq_addr;
   logic         sq_rd_en;
   logic         geom_en;
   cell_idx_type cell_a, cell_b;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign full      = (fill_ff == SQ_FULL);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_now  = ((state_ff == S_EMIT_A) || (state_ff == S_EMIT_B)) && out_free;
   assign csr_ready = 1'b1;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cipher_letter = rsp_letter_ff;
   assign rsp_last_of_run   = rsp_last_ff;

   assign req_folded = fold_j(req_letter);
   assign filler_now = (filler_ff > LETTER_MAX) ? LETTER_MAX : fold_j(filler_ff);

   // placement candidate: key letter on request, or the fill walk
   always_comb begin
      cand    = req_folded;
      cand_ok = 1'b0;
      if (state_ff == S_FILL) begin
         cand    = walk_ff;
         cand_ok = (walk_ff != LETTER_J);
      end else if (accept && mode_type'(req_mode) == MODE_KEY) begin
         cand_ok = (req_letter <= LETTER_MAX);
      end
      place_en = cand_ok && !full && !placed_ff[cand];
   end

   // memory read addresses per state
   always_comb begin
      pos_addr = (state_ff == S_POS_B) ? b_ff : a_ff;
      sq_addr  = (state_ff == S_CELL_B) ? cell_b : cell_a;
      sq_rd_en = (state_ff == S_CELL_A) || (state_ff == S_CELL_B);
      geom_en  = (state_ff == S_GEOM);
   end

   // square and position memories
   always_ff @(posedge clock) begin
      if (place_en) begin
         square_mem[fill_ff] <= cand;
         pos_mem[cand]       <= fill_ff;
      end
      pos_rd_ff <= pos_mem[pos_addr];
      if (sq_rd_en) begin
         sq_rd_ff <= square_mem[sq_addr];
      end
   end

   pfc_geom u_geom (
      .clock     (clock),
      .en        (geom_en),
      .pos_a     (p1_ff),
      .pos_b     (pos_rd_ff),
      .cell_a_ff (cell_a),
      .cell_b_ff (cell_b)
   );

   // sequencer, key state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         placed_ff      <= '0;
         fill_ff        <= '0;
         walk_ff        <= '0;
         pend_letter_ff <= '0;
         pend_valid_ff  <= 1'b0;
         filler_ff      <= LETTER_MAX;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            filler_ff <= csr_filler_letter;
         end
         if (place_en) begin
            placed_ff[cand] <= 1'b1;
            fill_ff         <= fill_ff + 5'd1;
         end
         // result valid: set on emit, dropped once taken
         if (emit_now) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  unique case (mode_type'(req_mode))
                     MODE_KEY: begin
                        // placement handled above
                     end
                     MODE_FINISH: begin
                        walk_ff  <= '0;
                        state_ff <= S_FILL;
                     end
                     MODE_PLAIN: begin
                        if (full && req_letter <= LETTER_MAX) begin
                           if (!pend_valid_ff) begin
                              pend_letter_ff <= req_folded;
                              pend_valid_ff  <= 1'b1;
                           end else begin
                              a_ff     <= pend_letter_ff;
                              state_ff <= S_POS_A;
                              if (pend_letter_ff == req_folded) begin
                                 // doubled letter: filler goes in, pair stays open
                                 b_ff <= filler_now;
                              end else begin
                                 b_ff          <= req_folded;
                                 pend_valid_ff <= 1'b0;
                              end
                           end
                        end
                     end
                     MODE_END: begin
                        if (full && pend_valid_ff) begin
                           a_ff          <= pend_letter_ff;
                           b_ff          <= filler_now;
                           pend_valid_ff <= 1'b0;
                           state_ff      <= S_POS_A;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_FILL: begin
               walk_ff <= walk_ff + 5'd1;
               if (walk_ff == LETTER_MAX) begin
                  state_ff <= S_IDLE;
               end
            end
            S_POS_A: state_ff <= S_POS_B;
            S_POS_B: begin
               p1_ff    <= pos_rd_ff;
               state_ff <= S_GEOM;
            end
            S_GEOM:   state_ff <= S_CELL_A;
            S_CELL_A: state_ff <= S_CELL_B;
            S_CELL_B: begin
               c1_ff    <= sq_rd_ff;
               state_ff <= S_EMIT_A;
            end
            S_EMIT_A: begin
               if (out_free) begin
                  rsp_letter_ff <= c1_ff;
                  rsp_last_ff   <= 1'b0;
                  state_ff      <= S_EMIT_B;
               end
            end
            S_EMIT_B: begin
               if (out_free) begin
                  rsp_letter_ff <= sq_rd_ff;
                  rsp_last_ff   <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

### rtl/pfc_geom.sv
// pfc_geom: digraph rule on two cell positions, registered target cells
`timescale 1ns / 1ps

module pfc_geom (
   input  logic                  clock,
   input  logic                  en,
   input  pfc_pkg::cell_idx_type pos_a,
   input  pfc_pkg::cell_idx_type pos_b,
   output pfc_pkg::cell_idx_type cell_a_ff,
   output pfc_pkg::cell_idx_type cell_b_ff
);
   import pfc_pkg::*;

   // row of a cell, by compare chain
   function automatic logic [2:0] row_of(input cell_idx_type p);
      priority if (p >= 5'(4 * SQ_SIDE)) return 3'd4;
      else if (p >= 5'(3 * SQ_SIDE))     return 3'd3;
      else if (p >= 5'(2 * SQ_SIDE))     return 3'd2;
      else if (p >= 5'(SQ_SIDE))         return 3'd1;
      else                               return 3'd0;
   endfunction

   function automatic cell_idx_type cell_at(input logic [2:0] r, input logic [2:0] c);
      return 5'(r) * 5'(SQ_SIDE) + 5'(c);
   endfunction

   function automatic logic [2:0] wrap_inc(input logic [2:0] v);
      return (v == 3'(SQ_SIDE - 1)) ? 3'd0 : v + 3'd1;
   endfunction

   logic [2:0]   r1, c1, r2, c2;
   cell_idx_type cell_a_in, cell_b_in;

   // split positions into row and column
   always_comb begin
      r1 = row_of(pos_a);
      r2 = row_of(pos_b);
      c1 = 3'(pos_a - cell_at(r1, 3'd0));
      c2 = 3'(pos_b - cell_at(r2, 3'd0));
   end

   // column shifts down, row shifts right, else columns swap
   always_comb begin
      priority if (c1 == c2) begin
         cell_a_in = cell_at(wrap_inc(r1), c1);
         cell_b_in = cell_at(wrap_inc(r2), c2);
      end else if (r1 == r2) begin
         cell_a_in = cell_at(r1, wrap_inc(c1));
         cell_b_in = cell_at(r2, wrap_inc(c2));
      end else begin
         cell_a_in = cell_at(r1, c2);
         cell_b_in = cell_at(r2, c1);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cell_a_ff <= cell_a_in;
         cell_b_ff <= cell_b_in;
      end
   end

endmodule

### rtl/pfc_checker.sv
// pfc_checker: port-level checks of the digraph cipher, bound to the top level
`timescale 1ns / 1ps

module pfc_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic [1:0]          req_mode,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input pfc_pkg::letter_type rsp_cipher_letter,
   input logic                rsp_last_of_run
);
   import pfc_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cipher_letter)
                                 && $stable(rsp_last_of_run))
      else $error("stalled result changed");

   // a cipher letter is a square letter: never j, never above z
   a_rsp_letter: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cipher_letter != LETTER_J && rsp_cipher_letter <= LETTER_MAX)
      else $error("cipher letter outside the square alphabet");

   // reset empties the result register
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a key letter never produces a result
   a_key_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_mode == MODE_KEY && !rsp_valid |=> !rsp_valid)
      else $error("result after key letter");

endmodule

bind playfair_digraph_cipher pfc_checker u_pfc_checker (.*);
